[sv/ctrk_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctrk_pkg
// Shared types and codes of the contact enter/stay/exit tracker.
// ----------------------------------------------------------------------------
package ctrk_pkg;

    localparam int ID_W  = 16;
    localparam int TAG_W = 16;

    typedef logic [ID_W-1:0]  id_t;
    typedef logic [TAG_W-1:0] tag_t;
    typedef logic [2:0]       kind_t;

    // input commands
    localparam logic CMD_REPORT = 1'b0;
    localparam logic CMD_EOF    = 1'b1;

    // event kinds
    localparam kind_t KIND_ENTER = 3'd0;
    localparam kind_t KIND_STAY  = 3'd1;
    localparam kind_t KIND_EXIT  = 3'd2;
    localparam kind_t KIND_DROP  = 3'd3;
    localparam kind_t KIND_DONE  = 3'd4;

    // classified item handed from front to back
    typedef struct packed {
        logic is_eof;
        id_t  id;
        tag_t tag;
    } item_t;

endpackage
`default_nettype wire

[sv/contact_enter_stay_exit_tracker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// contact_enter_stay_exit_tracker
// Tracks contacts across frames and reports enter, stay and exit events.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): command 0 reports a contact with
// other_id and contact_tag, command 1 closes the frame. Output channel
// (out_valid / out_stall): one event per transfer with event_kind, event_id,
// event_tag and last set on the final event caused by an input.
// A report gives one event (enter, stay, or dropped when the current list
// holds LIST_DEPTH entries). End of frame gives one exit per unmatched entry
// of the previous frame in stored order, or one done marker, then swaps lists.
// The first event of an item passes through the input queue, the back-end
// state register and the event register. A report passes the back end as a
// queue pop, then the parallel compare against the previous list; end of
// frame pops the item, then emits each exit event or the done marker.
// Reset empties both lists. A stall on the output holds the event register;
// the two-entry input queue keeps taking items until it fills.
// ----------------------------------------------------------------------------
module contact_enter_stay_exit_tracker #(
    parameter int LIST_DEPTH = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic           command,
    input  wire ctrk_pkg::id_t  other_id,
    input  wire ctrk_pkg::tag_t contact_tag,
    output logic                out_valid,
    input  wire logic           out_stall,
    output ctrk_pkg::kind_t     event_kind,
    output ctrk_pkg::id_t       event_id,
    output ctrk_pkg::tag_t      event_tag,
    output logic                last
);
    import ctrk_pkg::*;

    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    ctrk_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .other_id    (other_id),
        .contact_tag (contact_tag),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    ctrk_back #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_kind (event_kind),
        .event_id   (event_id),
        .event_tag  (event_tag),
        .last       (last)
    );

endmodule
`default_nettype wire

[sv/ctrk_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctrk_front
// Accepts input transfers, classifies them and holds them in a two-entry
// queue for the back end.
// ----------------------------------------------------------------------------
module ctrk_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic           command,
    input  wire ctrk_pkg::id_t  other_id,
    input  wire ctrk_pkg::tag_t contact_tag,
    output logic                q_valid,
    output ctrk_pkg::item_t     q_item,
    input  wire logic           q_pop
);
    import ctrk_pkg::*;

    item_t      fifo_mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    item_t      new_item;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        new_item.is_eof = (command == CMD_EOF);
        new_item.id     = other_id;
        new_item.tag    = contact_tag;
    end

    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= new_item;
        end
    end

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

[sv/ctrk_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctrk_back
// Matches reports against the previous frame's list, keeps the current list
// and emits events through an output register. Lists live in two banks that
// swap roles at end of frame.
// ----------------------------------------------------------------------------
module ctrk_back #(
    parameter int LIST_DEPTH = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    input  wire ctrk_pkg::item_t q_item,
    output logic                 q_pop,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output ctrk_pkg::kind_t      event_kind,
    output ctrk_pkg::id_t        event_id,
    output ctrk_pkg::tag_t       event_tag,
    output logic                 last
);
    import ctrk_pkg::*;

    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_EXIT
    } state_t;

    typedef logic [LIST_DEPTH-1:0] mask_t;

    // two banks: bank sel_reg holds the previous list, the other the current
    id_t  ids_mem  [2][LIST_DEPTH];
    tag_t tags_mem [2][LIST_DEPTH];

    state_t           state_reg;
    state_t           state_next;
    item_t            work_reg;
    item_t            work_next;
    logic             sel_reg;
    logic             sel_next;
    mask_t            live_reg;
    mask_t            live_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    kind_t            kind_reg;
    kind_t            kind_next;
    id_t              id_reg;
    id_t              id_next;
    tag_t             tag_reg;
    tag_t             tag_next;
    logic             last_reg;
    logic             last_next;

    logic             slot_free;
    logic             list_full;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic             swap;
    mask_t            hit;
    mask_t            hit_first;
    mask_t            exit_first;
    mask_t            live_rem;
    mask_t            fill_mask;
    id_t              exit_id;
    tag_t             exit_tag;

    assign out_valid  = out_valid_reg;
    assign event_kind = kind_reg;
    assign event_id   = id_reg;
    assign event_tag  = tag_reg;
    assign last       = last_reg;

    assign slot_free = !out_valid_reg || !out_stall;
    assign list_full = (count_reg == CNT_W'(LIST_DEPTH));
    assign wr_idx    = count_reg[IDX_W-1:0];

    // parallel compare against every live previous entry
    always_comb
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            hit[i]       = live_reg[i] && (ids_mem[sel_reg][i] == work_reg.id);
            fill_mask[i] = (CNT_W'(i) < count_reg);
        end
    end

    // isolate the lowest set bit
    assign hit_first  = hit & (~hit + mask_t'(1));
    assign exit_first = live_reg & (~live_reg + mask_t'(1));
    assign live_rem   = live_reg & ~exit_first;

    always_comb
    begin
        exit_id  = '0;
        exit_tag = '0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            exit_id  = exit_id  | ({ID_W{exit_first[i]}}  & ids_mem[sel_reg][i]);
            exit_tag = exit_tag | ({TAG_W{exit_first[i]}} & tags_mem[sel_reg][i]);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        work_next      = work_reg;
        sel_next       = sel_reg;
        live_next      = live_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        id_next        = id_reg;
        tag_next       = tag_reg;
        last_next      = last_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        swap           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    work_next  = q_item;
                    state_next = q_item.is_eof ? S_EXIT : S_MATCH;
                end
            end
            S_MATCH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    id_next        = work_reg.id;
                    tag_next       = work_reg.tag;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                    if (list_full)
                    begin
                        kind_next = KIND_DROP;
                    end
                    else
                    begin
                        kind_next  = (|hit) ? KIND_STAY : KIND_ENTER;
                        live_next  = live_reg & ~hit_first;
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            S_EXIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (live_reg == '0)
                    begin
                        kind_next = KIND_DONE;
                        id_next   = '0;
                        tag_next  = '0;
                        last_next = 1'b1;
                        swap      = 1'b1;
                    end
                    else
                    begin
                        kind_next = KIND_EXIT;
                        id_next   = exit_id;
                        tag_next  = exit_tag;
                        last_next = (live_rem == '0);
                        live_next = live_rem;
                        swap      = (live_rem == '0);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // current list becomes the previous list, all entries live
        if (swap)
        begin
            sel_next   = ~sel_reg;
            live_next  = fill_mask;
            count_next = '0;
            state_next = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            work_reg      <= '0;
            sel_reg       <= 1'b0;
            live_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= '0;
            id_reg        <= '0;
            tag_reg       <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            work_reg      <= work_next;
            sel_reg       <= sel_next;
            live_reg      <= live_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            id_reg        <= id_next;
            tag_reg       <= tag_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ids_mem[~sel_reg][wr_idx]  <= work_reg.id;
            tags_mem[~sel_reg][wr_idx] <= work_reg.tag;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LIST_DEPTH))
        else $error("current list count beyond depth");

    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_DONE) |-> (last_reg && id_reg == '0
            && tag_reg == '0))
        else $error("done marker malformed");

    a_swap_clears: assert property (@(posedge clk) disable iff (!rst_n)
        swap |=> (count_reg == '0 && sel_reg != $past(sel_reg)))
        else $error("frame swap did not clear current list");
`endif

endmodule
`default_nettype wire

[sim/ctrk_event_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctrk_event_checker
// Watches both channels of the contact tracker, keeps its own copy of the
// previous and current contact lists, and compares every event transfer
// against the oldest predicted event, field by field.
// ----------------------------------------------------------------------------
module ctrk_event_checker #(
    parameter int LIST_DEPTH = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            in_stall,
    input  wire logic            command,
    input  wire ctrk_pkg::id_t   other_id,
    input  wire ctrk_pkg::tag_t  contact_tag,
    input  wire logic            out_valid,
    input  wire logic            out_stall,
    input  wire ctrk_pkg::kind_t event_kind,
    input  wire ctrk_pkg::id_t   event_id,
    input  wire ctrk_pkg::tag_t  event_tag,
    input  wire logic            last,
    output int                   n_pending,
    output int                   n_errors,
    output int                   n_events,
    output int                   n_stays,
    output int                   n_exits,
    output int                   n_drops
);
    import ctrk_pkg::*;

    typedef struct {
        kind_t kind;
        id_t   id;
        tag_t  tag;
        logic  last;
    } contact_evt_t;

    contact_evt_t            pending_events[$];
    id_t                     prev_ids [LIST_DEPTH];
    tag_t                    prev_tags[LIST_DEPTH];
    logic [LIST_DEPTH-1:0]   prev_live;
    id_t                     cur_ids  [LIST_DEPTH];
    tag_t                    cur_tags [LIST_DEPTH];
    int                      cur_count;

    function automatic void push_event(kind_t kind, id_t id, tag_t tag, logic is_last);
        contact_evt_t e;
        e.kind = kind;
        e.id   = id;
        e.tag  = tag;
        e.last = is_last;
        pending_events.push_back(e);
    endfunction

    // Work out the events that one accepted command causes.
    function automatic void track_contact(logic cmd, id_t id, tag_t tag);
        bit hit;
        int n_live;
        int n_out;
        hit    = 1'b0;
        n_live = $countones(prev_live);
        n_out  = 0;
        if (cmd == CMD_REPORT) begin
            if (cur_count >= LIST_DEPTH) begin
                push_event(KIND_DROP, id, tag, 1'b1);
                return;
            end
            // first live entry with the same identity wins
            for (int k = 0; k < LIST_DEPTH; k++) begin
                if (!hit && prev_live[k] && prev_ids[k] == id) begin
                    prev_live[k] = 1'b0;
                    hit = 1'b1;
                end
            end
            cur_ids[cur_count]  = id;
            cur_tags[cur_count] = tag;
            cur_count++;
            push_event(hit ? KIND_STAY : KIND_ENTER, id, tag, 1'b1);
        end else begin
            if (n_live == 0)
                push_event(KIND_DONE, '0, '0, 1'b1);
            for (int k = 0; k < LIST_DEPTH; k++) begin
                if (prev_live[k]) begin
                    n_out++;
                    push_event(KIND_EXIT, prev_ids[k], prev_tags[k], n_out == n_live);
                end
            end
            // swap lists: this frame becomes the previous one, all live
            prev_live = '0;
            for (int k = 0; k < cur_count; k++) begin
                prev_ids[k]  = cur_ids[k];
                prev_tags[k] = cur_tags[k];
                prev_live[k] = 1'b1;
            end
            cur_count = 0;
        end
    endfunction

    function automatic void check_field(string what, logic [15:0] want_v,
                                        logic [15:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t ns: %s mismatch: expected %h, got %h", $time, what, want_v, got_v);
            n_errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        contact_evt_t want;
        if (!rst_n) begin
            pending_events.delete();
            prev_live = '0;
            cur_count = 0;
            n_errors  = 0;
            n_events  = 0;
            n_stays   = 0;
            n_exits   = 0;
            n_drops   = 0;
            n_pending <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                n_events++;
                if (event_kind == KIND_STAY) n_stays++;
                if (event_kind == KIND_EXIT) n_exits++;
                if (event_kind == KIND_DROP) n_drops++;
                if (pending_events.size() == 0) begin
                    $display("%0t ns: unexpected event: expected none, got kind %0d id %h tag %h",
                             $time, event_kind, event_id, event_tag);
                    n_errors++;
                end else begin
                    want = pending_events.pop_front();
                    check_field("event_kind", 16'(want.kind), 16'(event_kind));
                    check_field("event_id",   want.id,        event_id);
                    check_field("event_tag",  want.tag,       event_tag);
                    check_field("last",       16'(want.last), 16'(last));
                end
            end
            if (in_valid && !in_stall)
                track_contact(command, other_id, contact_tag);
            n_pending <= pending_events.size();
        end
    end

endmodule

[sim/tb_contact_enter_stay_exit_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_contact_enter_stay_exit_tracker
// Drives contact reports and end-of-frame commands into the tracker: a short
// directed sequence (empty frames, full list with drop, repeated identities,
// stays and exits), then random frames drawn from a small identity pool so
// that contacts persist across frames. Both channels idle at random outside a steady stretch.
// ----------------------------------------------------------------------------
module tb_contact_enter_stay_exit_tracker;
    import ctrk_pkg::*;

    localparam int LIST_DEPTH   = 16;
    localparam int TOTAL_ITEMS  = 420;
    localparam int IDLE_PCT     = 21;
    localparam int POOL_SIZE    = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;

    logic  clk         = 1'b0;
    logic  rst_n       = 1'b0;
    logic  in_valid    = 1'b0;
    logic  command     = CMD_REPORT;
    id_t   other_id    = '0;
    tag_t  contact_tag = '0;
    logic  out_stall   = 1'b0;
    logic  steady      = 1'b0;
    logic  in_stall;
    logic  out_valid;
    kind_t event_kind;
    id_t   event_id;
    tag_t  event_tag;
    logic  last;

    int    n_pending, n_errors, n_events, n_stays, n_exits, n_drops;
    int    cycle_count = 0;
    int    n_sent      = 0;
    int    n_frames    = 0;
    id_t   id_pool[POOL_SIZE];

    contact_enter_stay_exit_tracker #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .other_id    (other_id),
        .contact_tag (contact_tag),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_kind  (event_kind),
        .event_id    (event_id),
        .event_tag   (event_tag),
        .last        (last)
    );

    ctrk_event_checker #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .other_id    (other_id),
        .contact_tag (contact_tag),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_kind  (event_kind),
        .event_id    (event_id),
        .event_tag   (event_tag),
        .last        (last),
        .n_pending   (n_pending),
        .n_errors    (n_errors),
        .n_events    (n_events),
        .n_stays     (n_stays),
        .n_exits     (n_exits),
        .n_drops     (n_drops)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d events still due", cycle_count, n_pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Hold the command until it transfers; idle beforehand at random.
    task automatic send_item(logic cmd, id_t id, tag_t tag);
        if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        other_id    <= id;
        contact_tag <= tag;
        do @(posedge clk); while (in_stall);
        n_sent++;
        if (cmd == CMD_EOF)
            n_frames++;
    endtask

    initial
    begin
        int   n_rep;
        int   pick;
        id_t  rid;
        tag_t rtag;

        for (int k = 0; k < POOL_SIZE; k++)
            id_pool[k] = id_t'($urandom_range(0, 16'hFFFF));
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // end of frame with nothing live gives the done marker
        send_item(CMD_EOF, 16'hFFFF, 16'hFFFF);
        // fill the list with extremes and a repeated identity, then overflow
        for (int k = 0; k <= LIST_DEPTH; k++) begin
            case (k)
                0:          send_item(CMD_REPORT, 16'h0000, 16'hFFFF);
                1:          send_item(CMD_REPORT, 16'hFFFF, 16'h0000);
                2, 3:       send_item(CMD_REPORT, 16'h0005, tag_t'(16'h0A00 + k));
                LIST_DEPTH: send_item(CMD_REPORT, 16'hFFFF, 16'hABCD);
                default:    send_item(CMD_REPORT, id_t'(16'h0100 + k), tag_t'(k));
            endcase
        end
        send_item(CMD_EOF, 16'h0000, 16'h0000);
        // both copies of the repeated identity stay, a third one enters
        send_item(CMD_REPORT, 16'h0005, 16'h5555);
        send_item(CMD_REPORT, 16'h0005, 16'hAAAA);
        send_item(CMD_REPORT, 16'h0005, 16'h0001);
        send_item(CMD_REPORT, 16'hFFFF, 16'h8000);
        send_item(CMD_REPORT, 16'h1234, 16'h7FFF);
        send_item(CMD_EOF, 16'h0000, 16'hFFFF);

        while (n_sent < TOTAL_ITEMS) begin
            steady <= (n_sent >= 150 && n_sent < 260);
            pick = $urandom_range(0, 99);
            if (pick < 10)
                n_rep = 0;
            else if (pick < 22)
                n_rep = $urandom_range(LIST_DEPTH - 1, LIST_DEPTH + 3);
            else
                n_rep = $urandom_range(1, 12);
            for (int k = 0; k < n_rep; k++) begin
                if ($urandom_range(0, 99) < 75)
                    rid = id_pool[$urandom_range(0, POOL_SIZE - 1)];
                else
                    rid = id_t'($urandom_range(0, 16'hFFFF));
                rtag = tag_t'($urandom_range(0, 16'hFFFF));
                send_item(CMD_REPORT, rid, rtag);
            end
            send_item(CMD_EOF, id_t'($urandom_range(0, 16'hFFFF)),
                      tag_t'($urandom_range(0, 16'hFFFF)));
            // let the identity pool drift slowly
            id_pool[$urandom_range(0, POOL_SIZE - 1)] = id_t'($urandom_range(0, 16'hFFFF));
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (n_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d commands over %0d frames, %0d events checked", n_sent, n_frames,
                 n_events);
        $display("     %0d stays, %0d exits, %0d drops on a full list", n_stays, n_exits,
                 n_drops);
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
